[hdl/uer_pkg.sv]
// ----------------------------------------------------------------------------
// uer_pkg - shared types and constants of the echo ranger
// Word layouts, state record, register codes and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package uer_pkg;

  localparam int CntW   = 17;
  localparam int DistW  = 13;  // internal distance, holds up to 2259 cm plus sign
  localparam int OutDW  = 12;
  localparam int ThrW   = 11;
  localparam int PerW   = 16;
  localparam int TmoW   = 16;
  localparam int TickW  = 10;
  localparam int TimeW  = 32;

  localparam logic [CntW-1:0] CntMax = '1;

  // x / 58 == (x >> 1) / 29; the reciprocal is exact for any 16-bit dividend
  localparam logic [31:0] Div29Mult  = 32'd36158;
  localparam int          Div29Shift = 20;

  localparam logic CmdTick = 1'b0;
  localparam logic CmdPoll = 1'b1;

  localparam logic [1:0] CfgPeriod    = 2'd0;
  localparam logic [1:0] CfgThreshold = 2'd1;
  localparam logic [1:0] CfgTimeout   = 2'd2;
  localparam logic [1:0] CfgTick      = 2'd3;

  localparam logic [PerW-1:0]  PeriodRst    = 16'd80;
  localparam logic [ThrW-1:0]  ThresholdRst = 11'd20;
  localparam logic [TmoW-1:0]  TimeoutRst   = 16'd40000;
  localparam logic [TickW-1:0] TickRst      = 10'd50;
  localparam logic [DistW-1:0] DistNone     = '1;

  typedef struct packed {
    logic [PerW-1:0]  period_ms;
    logic [ThrW-1:0]  obstacle_threshold_cm;
    logic [TmoW-1:0]  timeout_us;
    logic [TickW-1:0] tick_us;
  } cfg_t;

  typedef struct packed {
    logic             command;
    logic             echo_level;
    logic [TimeW-1:0] now_ms;
  } item_t;

  typedef struct packed {
    logic [CntW-1:0]  echo_time;
    logic [CntW-1:0]  wait_time;
    logic             busy;
    logic [DistW-1:0] last_distance;
    logic [TimeW-1:0] last_start_ms;
  } state_t;

  typedef struct packed {
    logic             trigger_start;
    logic [OutDW-1:0] distance_cm;
    logic             measuring;
    logic             obstacle;
    logic             done_res;
    logic             timed_out;
  } result_t;

endpackage

`default_nettype wire

[hdl/uer_step.sv]
// ----------------------------------------------------------------------------
// uer_step - next-state and result logic for one word
// Poll start check, tick counting, finish with distance, timeout abort.
// ----------------------------------------------------------------------------
`default_nettype none

module uer_step (
  input  uer_pkg::item_t   item_i,
  input  uer_pkg::state_t  state_i,
  input  uer_pkg::cfg_t    cfg_i,
  output uer_pkg::state_t  state_o,
  output uer_pkg::result_t result_o
);

  logic [uer_pkg::TimeW-1:0] elapsed;
  logic [uer_pkg::CntW:0]    echo_sum;
  logic [uer_pkg::CntW:0]    wait_sum;
  logic [uer_pkg::CntW-1:0]  echo_sat;
  logic [uer_pkg::CntW-1:0]  wait_sat;
  logic [31:0]               prod;
  logic [uer_pkg::DistW-1:0] quot;
  logic                      trig;
  logic                      done;
  logic                      tmo;
  uer_pkg::state_t           nxt;

  assign elapsed  = item_i.now_ms - state_i.last_start_ms;
  assign echo_sum = {1'b0, state_i.echo_time} + (uer_pkg::CntW+1)'(cfg_i.tick_us);
  assign wait_sum = {1'b0, state_i.wait_time} + (uer_pkg::CntW+1)'(cfg_i.tick_us);
  assign echo_sat = echo_sum[uer_pkg::CntW] ? uer_pkg::CntMax
                                            : echo_sum[uer_pkg::CntW-1:0];
  assign wait_sat = wait_sum[uer_pkg::CntW] ? uer_pkg::CntMax
                                            : wait_sum[uer_pkg::CntW-1:0];

  assign prod = {16'd0, state_i.echo_time[uer_pkg::CntW-1:1]} * uer_pkg::Div29Mult;
  assign quot = {1'b0, prod[31:uer_pkg::Div29Shift]};

  always_comb begin
    nxt  = state_i;
    trig = 1'b0;
    done = 1'b0;
    tmo  = 1'b0;
    if (item_i.command == uer_pkg::CmdPoll) begin
      if (elapsed >= uer_pkg::TimeW'(cfg_i.period_ms) && !state_i.busy) begin
        nxt.last_start_ms = item_i.now_ms;
        nxt.echo_time     = '0;
        nxt.wait_time     = '0;
        nxt.busy          = 1'b1;
        trig              = 1'b1;
      end
    end else if (state_i.busy) begin
      if (item_i.echo_level) begin
        nxt.echo_time = echo_sat;
      end else if (state_i.echo_time != '0) begin
        nxt.last_distance = quot;
        nxt.busy          = 1'b0;
        done              = 1'b1;
      end else begin
        nxt.wait_time = wait_sat;
      end
      // abort check follows the update, so it can override a finish
      if (nxt.echo_time > uer_pkg::CntW'(cfg_i.timeout_us) ||
          nxt.wait_time > uer_pkg::CntW'(cfg_i.timeout_us)) begin
        nxt.last_distance = uer_pkg::DistNone;
        nxt.busy          = 1'b0;
        nxt.echo_time     = '0;
        nxt.wait_time     = '0;
        done              = 1'b0;
        tmo               = 1'b1;
      end
    end
  end

  assign state_o = nxt;

  assign result_o.trigger_start = trig;
  assign result_o.distance_cm   = nxt.last_distance[uer_pkg::OutDW-1:0];
  assign result_o.measuring     = nxt.busy;
  assign result_o.obstacle      = !nxt.last_distance[uer_pkg::DistW-1] &&
                                  (nxt.last_distance != '0) &&
                                  (nxt.last_distance[uer_pkg::DistW-2:0] <
                                   (uer_pkg::DistW-1)'(cfg_i.obstacle_threshold_cm));
  assign result_o.done_res      = done;
  assign result_o.timed_out     = tmo;

endmodule

`default_nettype wire

[hdl/ultrasonic_echo_ranger_core.sv]
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger_core - echo-pulse ranging controller
// Two-stage word pipeline around the measurement state and register file.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries a word: command_i = 1 is
//   a poll with now_ms_i, command_i = 0 is a sample tick with echo_level_i.
//   Each input word yields exactly one result word on the output channel
//   (out_valid_o / out_stall_i): trigger strobe, last distance (-1 = none or
//   timeout), measuring flag, obstacle flag, done and timeout strobes.
//   A word passes the input register, then the result register; throughput
//   is one word per cycle without receiver stalls, limited by the single
//   state update per word. The distance is a reciprocal multiply (one
//   16x16 multiplier) in the update stage.
//   When the receiver stalls, the result register holds and an empty input
//   register still takes one more word before in_stall_o rises.
//   Configuration (cfg_we_i, cfg_idx_i, cfg_data_i) writes one register per
//   cycle: 0 period_ms, 1 obstacle_threshold_cm, 2 timeout_us, 3 tick_us.
//   Reset restores register defaults (80, 20, 40000, 50), clears the
//   counters and busy, and sets the last distance to -1.
// ----------------------------------------------------------------------------
`default_nettype none

module ultrasonic_echo_ranger_core (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [1:0]         cfg_idx_i,
  input  wire logic [15:0]        cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic               command_i,
  input  wire logic               echo_level_i,
  input  wire logic [31:0]        now_ms_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic                    trigger_start_o,
  output logic signed [11:0]      distance_cm_o,
  output logic                    measuring_o,
  output logic                    obstacle_o,
  output logic                    done_res_o,
  output logic                    timed_out_o
);

  uer_pkg::cfg_t    cfg_q;
  uer_pkg::state_t  state_q;
  uer_pkg::state_t  state_d;
  uer_pkg::item_t   item_q;
  uer_pkg::result_t res_q;
  uer_pkg::result_t res_d;
  logic             in_valid_q;
  logic             in_valid_d;
  logic             out_valid_q;
  logic             out_valid_d;
  logic             advance;
  logic             in_take;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.period_ms             <= uer_pkg::PeriodRst;
      cfg_q.obstacle_threshold_cm <= uer_pkg::ThresholdRst;
      cfg_q.timeout_us            <= uer_pkg::TimeoutRst;
      cfg_q.tick_us               <= uer_pkg::TickRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        uer_pkg::CfgPeriod:    cfg_q.period_ms             <= cfg_data_i;
        uer_pkg::CfgThreshold: cfg_q.obstacle_threshold_cm <= cfg_data_i[uer_pkg::ThrW-1:0];
        uer_pkg::CfgTimeout:   cfg_q.timeout_us            <= cfg_data_i;
        uer_pkg::CfgTick:      cfg_q.tick_us               <= cfg_data_i[uer_pkg::TickW-1:0];
        default: ;
      endcase
    end
  end

  // handshake
  assign advance     = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o  = in_valid_q && !advance;
  assign in_take     = in_valid_i && !in_stall_o;
  assign in_valid_d  = in_take || (in_valid_q && !advance);
  assign out_valid_d = advance || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q.command    <= command_i;
      item_q.echo_level <= echo_level_i;
      item_q.now_ms     <= now_ms_i;
    end
  end

  uer_step u_step (
    .item_i   (item_q),
    .state_i  (state_q),
    .cfg_i    (cfg_q),
    .state_o  (state_d),
    .result_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.echo_time     <= '0;
      state_q.wait_time     <= '0;
      state_q.busy          <= 1'b0;
      state_q.last_distance <= uer_pkg::DistNone;
      state_q.last_start_ms <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign trigger_start_o = res_q.trigger_start;
  assign distance_cm_o   = $signed(res_q.distance_cm);
  assign measuring_o     = res_q.measuring;
  assign obstacle_o      = res_q.obstacle;
  assign done_res_o      = res_q.done_res;
  assign timed_out_o     = res_q.timed_out;

  a_done_xor_tmo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(res_q.done_res && res_q.timed_out))
    else $error("done and timeout in one word");

  a_trig_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.trigger_start) |-> res_q.measuring)
    else $error("trigger without measurement");

  a_tmo_dist: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.timed_out) |-> (res_q.distance_cm == '1 && !res_q.obstacle))
    else $error("timeout word must carry distance -1");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && (res_d.done_res || res_d.timed_out)) |=> !state_q.busy)
    else $error("measurement still busy after finish");

  a_no_stall_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |-> !in_stall_o)
    else $error("stall with empty input register");

endmodule

`default_nettype wire
